>>> hw/rtl/kba_pkg.sv
// ----------------------------------------------------------------------------
// kba_pkg: shared types, constants and table builder for the k-DOP core
// Holds the word widths, the function codes, the cell control and scan token
// types, and the elaboration-time builder of the direction lattice table.
// ----------------------------------------------------------------------------
package kba_pkg;

	// Word widths
	localparam int CoordW   = 32;                   // point coordinate, Q16.16
	localparam int CompW    = 18;                   // direction component, Q2.16
	localparam int DirW     = 3 * CompW;            // packed direction x, y, z
	localparam int BoundW   = 40;                   // bound and width, Q24.16
	localparam int ProdW    = CoordW + CompW;       // one coordinate product
	localparam int AccW     = ProdW + 2;            // sum of three products
	localparam int FracBits = 16;                   // fraction bits dropped
	localparam int MaxDirs  = 64;
	localparam int IdxW     = 6;
	localparam int CountW   = 7;

	localparam int DefaultDirectionCount = 33;

	typedef longint unsigned u64_t;

	localparam u64_t HalfPiQ30 = 64'd1686629713;
	localparam u64_t GoldenX2  = 64'd5308871539;

	// Function codes of an input word
	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_SET   = 2'd1,
		FUNC_MERGE = 2'd2
	} kba_func_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_LAUNCH,
		ST_SCAN,
		ST_DONE
	} kba_state_t;

	// Control broadcast to every cell
	typedef struct packed {
		logic mul_en;
		logic upd_en;
		logic set;
	} kba_cell_ctl_t;

	// Minimum-width token handed from cell to cell
	typedef struct packed {
		logic              valid;
		logic [BoundW-1:0] w;
		logic [IdxW-1:0]   idx;
	} kba_scan_t;

	typedef logic [MaxDirs-1:0][DirW-1:0] kba_dir_tab_t;

	typedef struct packed {
		logic [CountW-1:0] count;
		kba_dir_tab_t      tab;
	} kba_build_t;

	typedef struct packed {
		longint c;
		longint s;
	} kba_cs_t;

	// Restoring division, elaboration only
	function automatic u64_t kba_udiv(input u64_t num, input u64_t den);
		u64_t q;
		u64_t r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic u64_t kba_mag(input longint a);
		return (a < 0) ? u64_t'(-a) : u64_t'(a);
	endfunction

	// Integer square root, bit-pair method
	function automatic u64_t kba_isqrt(input u64_t v_in);
		u64_t v;
		u64_t res;
		u64_t bitv;
		v = v_in;
		res = '0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// a * b / 2^30, rounded half away from zero
	function automatic longint kba_mul_q30(input longint a, input longint b);
		u64_t m;
		m = (kba_mag(a) * kba_mag(b) + (64'd1 << 29)) >> 30;
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	// Cosine and sine of a turn fraction, Q30, truncated Taylor terms
	function automatic kba_cs_t kba_cos_sin(input logic [31:0] turn);
		u64_t    r;
		u64_t    x;
		u64_t    x2;
		u64_t    ts;
		u64_t    tc;
		longint  sv;
		longint  cv;
		kba_cs_t res;
		r  = u64_t'(turn[29:0]);
		x  = (r * HalfPiQ30) >> 30;
		x2 = (x * x) >> 30;
		ts = x;
		tc = 64'd1 << 30;
		sv = longint'(ts);
		cv = longint'(tc);
		for (int k = 1; k <= 8; k++) begin
			ts = kba_udiv((ts * x2) >> 30, u64_t'((2 * k) * (2 * k + 1)));
			tc = kba_udiv((tc * x2) >> 30, u64_t'((2 * k - 1) * (2 * k)));
			if (k % 2 == 1) begin
				sv = sv - longint'(ts);
				cv = cv - longint'(tc);
			end else begin
				sv = sv + longint'(ts);
				cv = cv + longint'(tc);
			end
		end
		unique case (turn[31:30])
			2'd0: begin res.c = cv;  res.s = sv;  end
			2'd1: begin res.c = -sv; res.s = cv;  end
			2'd2: begin res.c = -cv; res.s = -sv; end
			default: begin res.c = sv; res.s = -cv; end
		endcase
		return res;
	endfunction

	// Fibonacci lattice over 2n points, kept on the (0.8, 1.3, 1.5) side
	function automatic kba_build_t kba_build(input int n);
		kba_build_t res;
		longint     t;
		longint     m;
		longint     z;
		longint     sq;
		longint     x;
		longint     y;
		u64_t       zm;
		u64_t       dd;
		u64_t       root;
		u64_t       turn;
		kba_cs_t    cs;
		res = '0;
		t = 2 * longint'(n);
		for (longint i = 0; i < t; i++) begin
			m    = t - 2 * i - 1;
			zm   = kba_udiv(kba_mag(m) * 64'd131072 + u64_t'(t), u64_t'(2 * t));
			z    = (m < 0) ? -longint'(zm) : longint'(zm);
			dd   = u64_t'(t * t - m * m);
			root = kba_isqrt(dd << 32);
			sq   = longint'(kba_udiv(root + u64_t'(n), u64_t'(t)));
			turn = ((u64_t'(2 * i + 1) * GoldenX2) >> 1) & 64'hFFFF_FFFF;
			cs   = kba_cos_sin(turn[31:0]);
			x    = kba_mul_q30(sq, cs.c);
			y    = kba_mul_q30(sq, cs.s);
			if ((8 * x + 13 * y + 15 * z > 0) && (res.count < CountW'(MaxDirs))) begin
				res.tab[res.count[IdxW-1:0]] = {z[CompW-1:0], y[CompW-1:0], x[CompW-1:0]};
				res.count = res.count + CountW'(1);
			end
		end
		return res;
	endfunction

endpackage

>>> hw/rtl/kdop_bound_accumulator_core.sv
// ----------------------------------------------------------------------------
// kdop_bound_accumulator_core: k-DOP bounding region over a point stream
// Each input word clears the region, sets it to a point or merges a point;
// every word yields one result word with the thinnest extent and its index.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+------------------------------------
//   in      | in  | in_valid / in_stall | func, px, py, pz
//   out     | out | out_valid/out_stall | min_width, thin_index, is_empty
//
// The kept directions are fixed at elaboration, at most 64. An accepted word
// runs the sequencer through multiply, update, launch and scan; its result is
// registered as the sequencer leaves done, and no word is taken until it is
// back in idle. The width token walks the cell row, one cell per cycle. Reset
// leaves the region empty and the output register vacant. A stalled output
// holds the sequencer in done; the next word is taken while a result waits.
// ----------------------------------------------------------------------------
module kdop_bound_accumulator_core #(
	parameter int DIRECTION_COUNT = kba_pkg::DefaultDirectionCount
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        func,
	input  logic signed [kba_pkg::CoordW-1:0] px,
	input  logic signed [kba_pkg::CoordW-1:0] py,
	input  logic signed [kba_pkg::CoordW-1:0] pz,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [kba_pkg::BoundW-1:0]        min_width,
	output logic [kba_pkg::IdxW-1:0]          thin_index,
	output logic                              is_empty
);
	import kba_pkg::*;

	localparam kba_build_t Build    = kba_build(DIRECTION_COUNT);
	localparam int         DirCount = int'(Build.count);
	localparam bit         NoDirs   = (DirCount == 0);

	kba_state_t           state_q;
	kba_state_t           state_d;
	logic [1:0]           func_q;
	logic signed [CoordW-1:0] px_q;
	logic signed [CoordW-1:0] py_q;
	logic signed [CoordW-1:0] pz_q;
	logic                 empty_q;
	logic                 out_valid_q;
	logic [BoundW-1:0]    min_width_q;
	logic [IdxW-1:0]      thin_index_q;
	logic                 is_empty_q;
	logic                 accept;
	logic                 launch;
	logic                 load_out;
	logic                 region_upd;
	kba_cell_ctl_t        ctl;
	kba_scan_t            chain [DirCount+1];
	logic [DirCount:0]    chain_valid;
	kba_scan_t            tail;

	assign accept     = in_valid && !in_stall;
	assign region_upd = (func_q == FUNC_SET) || (func_q == FUNC_MERGE);

	// Input word capture
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			px_q   <= px;
			py_q   <= py;
			pz_q   <= pz;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_MUL;
			ST_MUL:    state_d = ST_UPD;
			ST_UPD:    state_d = ST_LAUNCH;
			ST_LAUNCH: state_d = tail.valid ? ST_DONE : ST_SCAN;
			ST_SCAN:   if (tail.valid) state_d = ST_DONE;
			ST_DONE:   if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		ctl.mul_en = (state_q == ST_MUL);
		ctl.upd_en = (state_q == ST_UPD) && region_upd;
		ctl.set    = (func_q == FUNC_SET) || empty_q;
		launch     = (state_q == ST_LAUNCH);
		load_out   = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Region empty flag; bounds of an empty region are never read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= 1'b1;
		end else if (state_q == ST_UPD) begin
			if (func_q == FUNC_CLEAR)
				empty_q <= 1'b1;
			else if (region_upd)
				empty_q <= 1'b0;
		end
	end

	// Cell row; the head token starts above any real width
	assign chain[0] = '{valid: launch, w: '1, idx: '0};

	for (genvar d = 0; d < DirCount; d++) begin : g_cell
		kba_cell #(
			.DIR        (Build.tab[d]),
			.CELL_INDEX (d)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.px       (px_q),
			.py       (py_q),
			.pz       (pz_q),
			.scan_in  (chain[d]),
			.scan_out (chain[d+1])
		);
	end

	for (genvar d = 0; d <= DirCount; d++) begin : g_chain_valid
		assign chain_valid[d] = chain[d].valid;
	end

	assign tail = chain[DirCount];

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (empty_q || NoDirs) begin
				min_width_q  <= '0;
				thin_index_q <= '0;
			end else begin
				min_width_q  <= tail.w;
				thin_index_q <= tail.idx;
			end
			is_empty_q <= empty_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign min_width  = min_width_q;
	assign thin_index = thin_index_q;
	assign is_empty   = is_empty_q;

	// At most one width token in the row at any time
	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(chain_valid))
		else $error("more than one width token in the cell row");

	// The token leaves the row only while the sequencer waits for it
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> (state_q == ST_LAUNCH || state_q == ST_SCAN))
		else $error("width token left the row outside the scan");

	// An empty region reports zero width at index zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_empty_q) |-> (min_width_q == '0 && thin_index_q == '0))
		else $error("empty region reported a nonzero width or index");

	// Reported index names a real direction
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !NoDirs) |-> (int'(thin_index_q) < DirCount))
		else $error("thin_index beyond the direction count");

	// A word is taken only with the row idle
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (chain_valid == '0))
		else $error("input word taken while a width token is in flight");

endmodule

>>> hw/rtl/kba_cell.sv
// ----------------------------------------------------------------------------
// kba_cell: one direction of the k-DOP bound row
// Projects the broadcast point onto a fixed direction, keeps the low and high
// bounds along it, and refines the minimum-width token passing through.
// ----------------------------------------------------------------------------
module kba_cell #(
	parameter logic [kba_pkg::DirW-1:0] DIR = '0,
	parameter int CELL_INDEX = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kba_pkg::kba_cell_ctl_t            ctl,
	input  logic signed [kba_pkg::CoordW-1:0] px,
	input  logic signed [kba_pkg::CoordW-1:0] py,
	input  logic signed [kba_pkg::CoordW-1:0] pz,
	input  kba_pkg::kba_scan_t                scan_in,
	output kba_pkg::kba_scan_t                scan_out
);
	import kba_pkg::*;

	localparam logic signed [CompW-1:0] DirX = DIR[CompW-1:0];
	localparam logic signed [CompW-1:0] DirY = DIR[2*CompW-1:CompW];
	localparam logic signed [CompW-1:0] DirZ = DIR[3*CompW-1:2*CompW];

	logic signed [ProdW-1:0]  prod_x_s1;
	logic signed [ProdW-1:0]  prod_y_s1;
	logic signed [ProdW-1:0]  prod_z_s1;
	logic signed [AccW-1:0]   acc;
	logic signed [BoundW-1:0] proj;
	logic signed [BoundW-1:0] low_q;
	logic signed [BoundW-1:0] high_q;
	logic [BoundW-1:0]        width;
	logic                     valid_q;
	logic [BoundW-1:0]        w_q;
	logic [IdxW-1:0]          idx_q;

	// Coordinate products, one multiplier per axis
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_x_s1 <= ProdW'(px) * ProdW'(DirX);
			prod_y_s1 <= ProdW'(py) * ProdW'(DirY);
			prod_z_s1 <= ProdW'(pz) * ProdW'(DirZ);
		end
	end

	// Exact sum, floored to Q24.16
	assign acc  = AccW'(prod_x_s1) + AccW'(prod_y_s1) + AccW'(prod_z_s1);
	assign proj = BoundW'($signed(acc[AccW-1:FracBits]));

	// Bound update: set overwrites, merge widens
	always_ff @(posedge clk) begin
		if (ctl.upd_en) begin
			if (ctl.set) begin
				low_q  <= proj;
				high_q <= proj;
			end else begin
				if (proj < low_q)
					low_q <= proj;
				if (proj > high_q)
					high_q <= proj;
			end
		end
	end

	assign width = BoundW'(high_q - low_q);

	// Token stage: strict less-than keeps the lowest index on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= scan_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_in.valid) begin
			if (width < scan_in.w) begin
				w_q   <= width;
				idx_q <= IdxW'(CELL_INDEX);
			end else begin
				w_q   <= scan_in.w;
				idx_q <= scan_in.idx;
			end
		end
	end

	assign scan_out = '{valid: valid_q, w: w_q, idx: idx_q};

endmodule
